@@ rtl/sdtw_pkg.sv @@
// Shared types and codes for the short-descriptor table walk core.
package sdtw_pkg;

  // Result kind carried on kind_o.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_e;

  // Fault code carried on fault_code_o.
  typedef enum logic [2:0] {
    FC_NONE         = 3'd0,
    FC_SECTION_XLAT = 3'd1,
    FC_PAGE_XLAT    = 3'd2,
    FC_DOMAIN       = 3'd3,
    FC_SECTION_PERM = 3'd4,
    FC_PAGE_PERM    = 3'd5,
    FC_UNSUPPORTED  = 3'd6
  } fault_code_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MMU_ENABLE      = 3'd0,
    CFG_SPLIT_WIDTH     = 3'd1,
    CFG_TABLE_BASE_ZERO = 3'd2,
    CFG_TABLE_BASE_ONE  = 3'd3,
    CFG_DOMAIN_ACCESS   = 3'd4
  } cfg_index_e;

  // Walk phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_L1   = 3'b010,
    PH_L2   = 3'b100
  } phase_e;

endpackage

@@ rtl/short_descriptor_table_walk_core.sv @@
// Top level of the two-level short-descriptor translation table walk core.
// Two-level 32-bit short-descriptor table walker. Each input transaction is
// either a translation request (mode 0) or a descriptor word returned from
// memory (mode 1); each produces at most one result transaction: a
// descriptor read request, a finished translation, or a fault. The core
// takes one input transaction per clock cycle unless a result stalls on
// out_ready_i; each is captured in an input register, decoded by one level
// of shift, mask and compare logic, and lands in the result register.
// The result register and the input register are separate stages, so a new
// transaction is taken while a finished result waits on out_ready_i.
// A descriptor that arrives with no walk in progress is dropped silently; a
// new request abandons any walk in progress. Configuration writes via
// cfg_we_i take effect on the next clock edge and should only be issued
// while no transaction is in flight.
module short_descriptor_table_walk_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] virtual_address_i,
  input  logic        write_access_i,
  input  logic        privileged_i,
  input  logic [31:0] descriptor_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [2:0]  fault_code_o,
  output logic [31:0] fault_address_o
);

  // Configuration registers
  logic        mmu_enable_q;
  logic [2:0]  split_width_q;
  logic [31:0] table_base_zero_q;
  logic [31:0] table_base_one_q;
  logic [31:0] domain_access_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mmu_enable_q      <= 1'b0;
      split_width_q     <= 3'd0;
      table_base_zero_q <= 32'd0;
      table_base_one_q  <= 32'd0;
      domain_access_q   <= 32'd0;
    end else if (cfg_we_i) begin
      case (sdtw_pkg::cfg_index_e'(cfg_index_i))
        sdtw_pkg::CFG_MMU_ENABLE:      mmu_enable_q      <= cfg_data_i[0];
        sdtw_pkg::CFG_SPLIT_WIDTH:     split_width_q     <= cfg_data_i[2:0];
        sdtw_pkg::CFG_TABLE_BASE_ZERO: table_base_zero_q <= cfg_data_i;
        sdtw_pkg::CFG_TABLE_BASE_ONE:  table_base_one_q  <= cfg_data_i;
        sdtw_pkg::CFG_DOMAIN_ACCESS:   domain_access_q   <= cfg_data_i;
        default: ; // indexes beyond the register list are ignored
      endcase
    end
  end

  // Input register stage
  logic        in_valid_q;
  logic        mode_q;
  logic [31:0] va_q;
  logic        wr_q;
  logic        priv_q;
  logic [31:0] desc_q;
  logic        advance;

  // The input stage drains whenever the result register can take its result.
  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      va_q   <= virtual_address_i;
      wr_q   <= write_access_i;
      priv_q <= privileged_i;
      desc_q <= descriptor_i;
    end
  end

  // Walk state
  sdtw_pkg::phase_e phase_q, phase_d;
  logic [31:0] pend_addr_q, pend_addr_d;
  logic        pend_wr_q, pend_wr_d;
  logic        pend_priv_q, pend_priv_d;
  logic [31:0] l1_entry_q, l1_entry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sdtw_pkg::PH_IDLE;
      pend_addr_q <= 32'd0;
      pend_wr_q   <= 1'b0;
      pend_priv_q <= 1'b0;
      l1_entry_q  <= 32'd0;
    end else if (advance) begin
      phase_q     <= phase_d;
      pend_addr_q <= pend_addr_d;
      pend_wr_q   <= pend_wr_d;
      pend_priv_q <= pend_priv_d;
      l1_entry_q  <= l1_entry_d;
    end
  end

  // Pick the 2-bit field of the domain access register for a domain.
  function automatic logic [1:0] domain_value(input logic [31:0] dacr,
                                              input logic [3:0]  dom);
    return dacr[{dom, 1'b0} +: 2];
  endfunction

  // True when the access permission bits deny the pending access.
  function automatic logic perm_denied(input logic ap2, input logic [1:0] ap10,
                                       input logic wr, input logic pr);
    logic deny;
    if (ap2) begin
      case (ap10)
        2'b00:   deny = 1'b1;
        2'b01:   deny = wr || !pr;
        default: deny = wr;
      endcase
    end else begin
      case (ap10)
        2'b00:   deny = 1'b1;
        2'b01:   deny = !pr;
        2'b10:   deny = wr && !pr;
        default: deny = 1'b0;
      endcase
    end
    return deny;
  endfunction

  // Level-1 descriptor address from the split width and the two bases.
  logic [31:0] top_mask;
  logic        use_base_zero;
  logic [31:0] l1_base;
  logic [11:0] l1_idx;
  logic [31:0] l1_addr;

  always_comb begin
    top_mask      = ~(32'hffff_ffff >> split_width_q);
    use_base_zero = (va_q & top_mask) == 32'd0;
    if (use_base_zero) begin
      l1_base = table_base_zero_q & (32'hffff_ffff << (5'd14 - {2'b00, split_width_q}));
      l1_idx  = va_q[31:20] & (12'hfff >> split_width_q);
    end else begin
      l1_base = table_base_one_q & 32'hffff_c000;
      l1_idx  = va_q[31:20];
    end
    l1_addr = l1_base | {18'd0, l1_idx, 2'b00};
  end

  // Descriptor decode
  logic [1:0] sec_dv;
  logic [1:0] pg_dv;
  logic       sec_super;

  assign sec_super = desc_q[18];
  assign sec_dv    = domain_value(domain_access_q, sec_super ? 4'd0 : desc_q[8:5]);
  assign pg_dv     = domain_value(domain_access_q, l1_entry_q[8:5]);

  logic                    res_valid;
  sdtw_pkg::kind_e         res_kind;
  logic [31:0]             res_addr;
  sdtw_pkg::fault_code_e   res_fc;
  logic                    res_fault;

  always_comb begin
    phase_d     = phase_q;
    pend_addr_d = pend_addr_q;
    pend_wr_d   = pend_wr_q;
    pend_priv_d = pend_priv_q;
    l1_entry_d  = l1_entry_q;
    res_valid   = 1'b0;
    res_kind    = sdtw_pkg::KIND_DONE;
    res_addr    = 32'd0;
    res_fc      = sdtw_pkg::FC_NONE;
    res_fault   = 1'b0;

    if (!mode_q) begin
      // New request: latch it and abandon any walk in progress.
      pend_addr_d = va_q;
      pend_wr_d   = wr_q;
      pend_priv_d = priv_q;
      res_valid   = 1'b1;
      if (!mmu_enable_q) begin
        phase_d  = sdtw_pkg::PH_IDLE;
        res_kind = sdtw_pkg::KIND_DONE;
        res_addr = va_q;
      end else begin
        phase_d  = sdtw_pkg::PH_L1;
        res_kind = sdtw_pkg::KIND_READ;
        res_addr = l1_addr;
      end
    end else begin
      case (phase_q)
        sdtw_pkg::PH_L1: begin
          res_valid = 1'b1;
          if (desc_q[1:0] == 2'b00 || desc_q[1:0] == 2'b11) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_SECTION_XLAT;
          end else if (desc_q[1:0] == 2'b01) begin
            // Coarse table: fetch the level-2 descriptor.
            l1_entry_d = desc_q;
            phase_d    = sdtw_pkg::PH_L2;
            res_kind   = sdtw_pkg::KIND_READ;
            res_addr   = {desc_q[31:10], pend_addr_q[19:12], 2'b00};
          end else if (sec_dv == 2'd0 || sec_dv == 2'd2) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_DOMAIN;
          end else if (sec_dv == 2'd1 &&
                       perm_denied(desc_q[15], desc_q[11:10], pend_wr_q, pend_priv_q)) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_SECTION_PERM;
          end else if (sec_super) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_UNSUPPORTED;
          end else begin
            phase_d  = sdtw_pkg::PH_IDLE;
            res_kind = sdtw_pkg::KIND_DONE;
            res_addr = {desc_q[31:20], pend_addr_q[19:0]};
          end
        end
        sdtw_pkg::PH_L2: begin
          res_valid = 1'b1;
          if (desc_q[1:0] == 2'b00) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_PAGE_XLAT;
          end else if (pg_dv == 2'd0 || pg_dv == 2'd2) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_DOMAIN;
          end else if (pg_dv == 2'd1 &&
                       perm_denied(desc_q[9], desc_q[5:4], pend_wr_q, pend_priv_q)) begin
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_PAGE_PERM;
          end else if (desc_q[1:0] == 2'b01) begin
            // Large page
            res_fault = 1'b1;
            res_fc    = sdtw_pkg::FC_UNSUPPORTED;
          end else begin
            phase_d  = sdtw_pkg::PH_IDLE;
            res_kind = sdtw_pkg::KIND_DONE;
            res_addr = {desc_q[31:12], pend_addr_q[11:0]};
          end
        end
        default: begin
          // Descriptor with no walk in progress: drop it.
          phase_d = sdtw_pkg::PH_IDLE;
        end
      endcase
      if (res_fault) begin
        phase_d  = sdtw_pkg::PH_IDLE;
        res_kind = sdtw_pkg::KIND_FAULT;
        res_addr = 32'd0;
      end
    end
  end

  // Result register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [31:0] address_q;
  logic [2:0]  fault_code_q;
  logic [31:0] fault_address_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      kind_q          <= res_kind;
      address_q       <= res_addr;
      fault_code_q    <= res_fc;
      fault_address_q <= res_fault ? pend_addr_q : 32'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign address_o       = address_q;
  assign fault_code_o    = fault_code_q;
  assign fault_address_o = fault_address_q;

endmodule

@@ rtl/sdtw_checker.sv @@
// Port-level assertions for the table walk core, bound to the top level.
module sdtw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] address_o,
  input logic [2:0]  fault_code_o,
  input logic [31:0] fault_address_o
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(address_o) && $stable(fault_code_o) && $stable(fault_address_o))
    else $error("result changed while stalled");

  // A fault code is present exactly on fault results.
  a_fc_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == sdtw_pkg::KIND_FAULT) ==
                     (fault_code_o != sdtw_pkg::FC_NONE)))
    else $error("fault code does not match kind");

  a_faddr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != sdtw_pkg::KIND_FAULT |-> fault_address_o == 32'd0)
    else $error("fault address on a non-fault result");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == sdtw_pkg::KIND_FAULT |-> address_o == 32'd0)
    else $error("address on a fault result");

endmodule

bind short_descriptor_table_walk_core sdtw_checker u_sdtw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .address_o       (address_o),
  .fault_code_o    (fault_code_o),
  .fault_address_o (fault_address_o)
);
